[src/hak_pkg.sv]
// ----------------------------------------------------------------------------
// Heatmap argmax keypoint package
// Payload types shared by the stages of the keypoint peak search.
// ----------------------------------------------------------------------------
package hak_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned CoordWidth = 6;
  localparam int unsigned JointWidth = 5;

  localparam logic signed [ValueWidth-1:0] ThresholdReset = 16'sd1638;
  localparam logic signed [ValueWidth-1:0] ValueMin       = 16'sh8000;

  typedef struct packed {
    logic signed [ValueWidth-1:0] sample;
    logic                         last_of_batch;
  } hak_in_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] peak_value;
    logic [CoordWidth-1:0]        peak_x;
    logic [CoordWidth-1:0]        peak_y;
    logic                         found;
    logic [JointWidth-1:0]        joint_index;
    logic                         last_joint;
  } hak_out_t;

  typedef struct packed {
    logic    valid;
    hak_in_t data;
  } hak_item_t;

  typedef struct packed {
    logic     valid;
    hak_out_t data;
  } hak_res_t;

endpackage

[src/hak_in_stage.sv]
// ----------------------------------------------------------------------------
// Heatmap argmax input stage
// Registers one incoming sample and holds it while the result side is stalled.
// ----------------------------------------------------------------------------
module hak_in_stage import hak_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hak_in_t   in_data_i,
  input  logic      advance_i,
  output hak_item_t item_o
);

  logic    valid_q, valid_d;
  hak_in_t data_q;

  assign in_stall_o = valid_q && !advance_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;

endmodule

[src/hak_track.sv]
// ----------------------------------------------------------------------------
// Heatmap argmax tracker
// Keeps the running maximum, raster position and joint count, and forms the
// result of a map on its final sample.
// ----------------------------------------------------------------------------
module hak_track import hak_pkg::*; #(
  parameter int unsigned MAP_WIDTH  = 48,
  parameter int unsigned MAP_HEIGHT = 64,
  parameter int unsigned JOINTS     = 17
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hak_item_t                    item_i,
  input  logic                         advance_i,
  input  logic signed [ValueWidth-1:0] threshold_i,
  output hak_res_t                     res_o
);

  localparam int unsigned ColW   = $clog2(MAP_WIDTH);
  localparam int unsigned RowW   = $clog2(MAP_HEIGHT);
  localparam int unsigned JointW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  logic signed [ValueWidth-1:0] best_value_q, best_value_d;
  logic [ColW-1:0]              best_col_q, best_col_d, col_count_q, col_count_d;
  logic [RowW-1:0]              best_row_q, best_row_d, row_count_q, row_count_d;
  logic [JointW-1:0]            joint_count_q, joint_count_d;

  logic                         fire, sample_gt, col_last, row_last, map_end;
  logic                         found, last;
  logic signed [ValueWidth-1:0] new_value;
  logic [ColW-1:0]              new_col;
  logic [RowW-1:0]              new_row;

  assign fire      = item_i.valid && advance_i;
  assign sample_gt = $signed(item_i.data.sample) > best_value_q;
  assign new_value = sample_gt ? item_i.data.sample : best_value_q;
  assign new_col   = sample_gt ? col_count_q : best_col_q;
  assign new_row   = sample_gt ? row_count_q : best_row_q;
  assign col_last  = col_count_q == ColW'(MAP_WIDTH - 1);
  assign row_last  = row_count_q == RowW'(MAP_HEIGHT - 1);
  assign map_end   = item_i.data.last_of_batch || (col_last && row_last);
  assign found     = new_value > threshold_i;
  assign last      = item_i.data.last_of_batch || (joint_count_q == JointW'(JOINTS - 1));

  always_comb begin
    best_value_d  = best_value_q;
    best_col_d    = best_col_q;
    best_row_d    = best_row_q;
    col_count_d   = col_count_q;
    row_count_d   = row_count_q;
    joint_count_d = joint_count_q;
    if (fire) begin
      if (map_end) begin
        best_value_d  = ValueMin;
        best_col_d    = '0;
        best_row_d    = '0;
        col_count_d   = '0;
        row_count_d   = '0;
        joint_count_d = last ? '0 : joint_count_q + 1'b1;
      end else begin
        best_value_d = new_value;
        best_col_d   = new_col;
        best_row_d   = new_row;
        if (col_last) begin
          col_count_d = '0;
          row_count_d = row_count_q + 1'b1;
        end else begin
          col_count_d = col_count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_value_q  <= ValueMin;
      best_col_q    <= '0;
      best_row_q    <= '0;
      col_count_q   <= '0;
      row_count_q   <= '0;
      joint_count_q <= '0;
    end else begin
      best_value_q  <= best_value_d;
      best_col_q    <= best_col_d;
      best_row_q    <= best_row_d;
      col_count_q   <= col_count_d;
      row_count_q   <= row_count_d;
      joint_count_q <= joint_count_d;
    end
  end

  assign res_o.valid            = item_i.valid && map_end;
  assign res_o.data.peak_value  = new_value;
  assign res_o.data.peak_x      = found ? CoordWidth'(new_col) : '0;
  assign res_o.data.peak_y      = found ? CoordWidth'(new_row) : '0;
  assign res_o.data.found       = found;
  assign res_o.data.joint_index = JointWidth'(joint_count_q);
  assign res_o.data.last_joint  = last;

endmodule

[src/hak_out_stage.sv]
// ----------------------------------------------------------------------------
// Heatmap argmax output stage
// Result register that holds a keypoint until the receiver takes it.
// ----------------------------------------------------------------------------
module hak_out_stage import hak_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  hak_res_t res_i,
  output logic     advance_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hak_out_t out_data_o
);

  logic     valid_q, valid_d;
  hak_out_t data_q;

  assign advance_o = !valid_q || !out_stall_i;
  assign valid_d   = advance_o ? res_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.valid) begin
      data_q <= res_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[src/heatmap_argmax_keypoint.sv]
// ----------------------------------------------------------------------------
// Heatmap argmax keypoint
// Finds the first maximum of each joint heatmap and reports it as a keypoint.
//
//   Channel   Signals                       Transaction
//   input     in_valid_i / in_stall_o       one heatmap sample
//   output    out_valid_o / out_stall_i     one keypoint per finished map
//   config    cfg_we_i / cfg_wdata_i        peak threshold write
//
// A sample is taken every cycle while the input is not stalled. If it closes a
// map, its keypoint goes from the input register through the compare and
// update straight into the result register.
// Reset clears the counters and the running maximum and sets the threshold to 0.4.
// A stalled result holds the result register; the input register then fills
// and the input stalls in turn.
// ----------------------------------------------------------------------------
module heatmap_argmax_keypoint import hak_pkg::*; #(
  parameter int unsigned MAP_WIDTH  = 48,
  parameter int unsigned MAP_HEIGHT = 64,
  parameter int unsigned JOINTS     = 17
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  hak_in_t                      in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output hak_out_t                     out_data_o,
  input  logic                         cfg_we_i,
  input  logic signed [ValueWidth-1:0] cfg_wdata_i
);

  logic signed [ValueWidth-1:0] threshold_q;
  hak_item_t                    item;
  hak_res_t                     res;
  logic                         advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  hak_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .item_o     (item)
  );

  hak_track #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT),
    .JOINTS     (JOINTS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .advance_i   (advance),
    .threshold_i (threshold_q),
    .res_o       (res)
  );

  hak_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register could advance");

  a_joint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.joint_index < JOINTS))
    else $error("joint index beyond joint count");

  a_final_joint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.joint_index == JOINTS - 1)) |-> out_data_o.last_joint)
    else $error("final joint not marked as last");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |->
      ((out_data_o.peak_x == '0) && (out_data_o.peak_y == '0)))
    else $error("invalid keypoint carries a position");

endmodule

[tb/sv/heatmap_argmax_keypoint_tb.sv]
// ----------------------------------------------------------------------------
// Heatmap argmax keypoint testbench
// Streams heatmap samples through the peak search and checks each keypoint
// against a running model of the block. The model tracks the first maximum,
// the raster position and the joint count. Short and long batches are sent
// under several peak thresholds. Both channels idle at random, and the
// receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module heatmap_argmax_keypoint_tb;
  import hak_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MapWidth   = 48;
  localparam int unsigned MapHeight  = 64;
  localparam int unsigned Joints     = 17;
  localparam int unsigned PipeDepth  = 2;
  localparam int unsigned HoldAt     = 40;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PrintCap   = 40;
  localparam longint      TimeoutNs  = 5_000_000;

  typedef enum int {FlavorWide, FlavorNearThreshold, FlavorExtreme} flavor_e;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  hak_in_t                      in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  hak_out_t                     out_data_o;
  logic                         cfg_we_i    = 1'b0;
  logic signed [ValueWidth-1:0] cfg_wdata_i = '0;

  hak_in_t  sample_q[$];
  hak_out_t keypoint_q[$];
  hak_out_t kp_want;

  logic signed [ValueWidth-1:0] threshold = ThresholdReset;
  logic signed [ValueWidth-1:0] run_max   = ValueMin;
  int unsigned max_col   = 0;
  int unsigned max_row   = 0;
  int unsigned col_pos   = 0;
  int unsigned row_pos   = 0;
  int unsigned joint_pos = 0;

  int unsigned send_pct   = 30;
  int unsigned recv_pct   = 46;
  int unsigned sent_count;
  int unsigned hold_left;
  logic        hold_done;
  int unsigned mismatches = 0;

  heatmap_argmax_keypoint #(
    .MAP_WIDTH (MapWidth),
    .MAP_HEIGHT(MapHeight),
    .JOINTS    (Joints)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void track_sample(hak_in_t item);
    logic     map_done;
    logic     closes_box;
    hak_out_t kp;
    if ($signed(item.sample) > run_max) begin
      run_max = item.sample;
      max_col = col_pos;
      max_row = row_pos;
    end
    map_done = item.last_of_batch || (col_pos == MapWidth - 1 && row_pos == MapHeight - 1);
    if (!map_done) begin
      if (col_pos == MapWidth - 1) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
      return;
    end
    closes_box = item.last_of_batch || joint_pos == Joints - 1;
    kp.peak_value  = run_max;
    kp.found       = run_max > threshold;
    kp.peak_x      = kp.found ? CoordWidth'(max_col) : '0;
    kp.peak_y      = kp.found ? CoordWidth'(max_row) : '0;
    kp.joint_index = JointWidth'(joint_pos);
    kp.last_joint  = closes_box;
    keypoint_q.insert(keypoint_q.size(), kp);
    run_max = ValueMin;
    max_col = 0;
    max_row = 0;
    col_pos = 0;
    row_pos = 0;
    joint_pos = closes_box ? 0 : joint_pos + 1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      sent_count <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_sample(in_data_i);
        sent_count <= sent_count + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (keypoint_q.size() == 0) begin
          report_mismatch("keypoint with none pending, joint_index",
                          int'(out_data_o.joint_index), -1);
        end else begin
          kp_want = keypoint_q.pop_front();
          if (out_data_o.peak_value !== kp_want.peak_value)
            report_mismatch("peak_value", int'($signed(out_data_o.peak_value)),
                            int'($signed(kp_want.peak_value)));
          if (out_data_o.peak_x !== kp_want.peak_x)
            report_mismatch("peak_x", int'(out_data_o.peak_x), int'(kp_want.peak_x));
          if (out_data_o.peak_y !== kp_want.peak_y)
            report_mismatch("peak_y", int'(out_data_o.peak_y), int'(kp_want.peak_y));
          if (out_data_o.found !== kp_want.found)
            report_mismatch("found", int'(out_data_o.found), int'(kp_want.found));
          if (out_data_o.joint_index !== kp_want.joint_index)
            report_mismatch("joint_index", int'(out_data_o.joint_index),
                            int'(kp_want.joint_index));
          if (out_data_o.last_joint !== kp_want.last_joint)
            report_mismatch("last_joint", int'(out_data_o.last_joint),
                            int'(kp_want.last_joint));
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_pct);
    end
  end

  function automatic void push_sample(logic signed [ValueWidth-1:0] value, logic batch_end);
    sample_q.insert(sample_q.size(), hak_in_t'{sample: value, last_of_batch: batch_end});
  endfunction

  function automatic logic signed [ValueWidth-1:0] pick_sample(flavor_e flavor);
    case (flavor)
      FlavorWide: begin
        return ValueWidth'($urandom());
      end
      FlavorNearThreshold: begin
        return ValueWidth'(int'(threshold) + int'($urandom_range(4)) - 2);
      end
      default: begin
        case ($urandom_range(3))
          0: return ValueMin;
          1: return 16'sh7fff;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic void queue_random_batches(int unsigned budget);
    int unsigned queued;
    int unsigned len;
    int unsigned roll;
    flavor_e     flavor;
    queued = 0;
    while (queued < budget) begin
      roll = $urandom_range(99);
      if (roll < 70) len = $urandom_range(30, 1);
      else if (roll < 95) len = $urandom_range(150, 31);
      else len = $urandom_range(400, 151);
      flavor = flavor_e'($urandom_range(2));
      for (int i = 0; i < len; i++) begin
        push_sample(pick_sample(flavor), i == len - 1);
      end
      queued += len;
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || keypoint_q.size() != 0);
    repeat (PipeDepth + 2) @(negedge clk_i);
  endtask

  task automatic set_threshold(logic signed [ValueWidth-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    threshold = value;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_sample(16'sh7fff, 1'b1);
    push_sample(ValueMin, 1'b1);
    push_sample(ThresholdReset, 1'b1);
    push_sample(ThresholdReset + 16'sd1, 1'b1);
    push_sample(16'sd5, 1'b0);
    push_sample(16'sd9, 1'b0);
    push_sample(16'sd9, 1'b0);
    push_sample(16'sd3, 1'b0);
    push_sample(16'sd9, 1'b1);
    push_sample(ValueMin, 1'b0);
    push_sample(ValueMin, 1'b0);
    push_sample(ValueMin, 1'b1);
    push_sample(-16'sd100, 1'b0);
    push_sample(-16'sd50, 1'b0);
    push_sample(-16'sd50, 1'b0);
    push_sample(-16'sd200, 1'b1);
    push_sample('0, 1'b1);
    queue_random_batches(350);
    wait_idle();

    set_threshold(ValueMin);
    queue_random_batches(350);
    wait_idle();

    send_pct = 46;
    recv_pct = 30;
    set_threshold(16'sh7fff);
    queue_random_batches(350);
    wait_idle();

    set_threshold('0);
    queue_random_batches(350);
    wait_idle();

    send_pct = 0;
    recv_pct = 0;
    set_threshold(ValueWidth'($urandom_range(4000)));
    for (int i = 0; i < 5; i++) begin
      push_sample(pick_sample(FlavorWide), i == 4);
    end
    queue_random_batches(150);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("Verification failed");
    $finish;
  end

endmodule
